[hw/rtl/ssrch_pkg.sv]
// ssrch_pkg: shared types, constants and helpers of the substring search stream
// used by ssrch_cell, ssrch_track and substring_search_stream; no dependencies
package ssrch_pkg;

    // fixed widths of the register and stream fields
    localparam int LEN_W           = 5;
    localparam int PAT_BYTES       = 16;
    localparam int PAT_IDX_W       = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int OUT_OFFSET_W    = 32;

    // defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 3'd0,
        CFG_PAT_HI  = 3'd1,
        CFG_PAT_LEN = 3'd2,
        CFG_FOLD    = 3'd3,
        CFG_LAST    = 3'd4
    } t_cfg_reg;

    // per-request control from the window chain to the tracker
    typedef struct packed {
        logic accept;
        logic take;
        logic last;
        logic all_eq;
    } t_step;

    // search mode as seen by the tracker
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             lead_nul;
        logic             search_last;
    } t_mode;

    // end-of-text decision
    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] offset;
    } t_result;

    // ascii A-Z to a-z when folding is on
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

[hw/rtl/ssrch_cell.sv]
// ssrch_cell: one window byte of the text shift chain with its pattern compare
// depends on ssrch_pkg (fold_byte)
module ssrch_cell
    import ssrch_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_din,
    input  logic [7:0] i_pat,
    input  logic       i_active,
    input  logic       i_fold,
    output logic [7:0] o_byte,
    output logic       o_eq
);

    logic [7:0] r_byte;

    // compare the byte that enters this cell on the current shift
    assign o_eq   = !i_active || (fold_byte(i_din, i_fold) == fold_byte(i_pat, i_fold));
    assign o_byte = r_byte;

    // window byte, cleared at end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_clear) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_din;
        end
    end

endmodule

[hw/rtl/ssrch_track.sv]
// ssrch_track: byte count, occurrence record and end-of-text decision
// depends on ssrch_pkg (t_step, t_mode, t_result)
module ssrch_track
    import ssrch_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_step   i_step,
    input  t_mode   i_mode,
    output t_result o_res
);

    localparam logic [OFFSET_BITS-1:0] OffsetMax = {OFFSET_BITS{1'b1}};

    logic [OFFSET_BITS-1:0] r_seen, n_seen;
    logic                   r_hit, n_hit;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] len_ext;
    logic                   trivial;
    logic                   match;

    assign len_ext = OFFSET_BITS'(i_mode.len);
    assign trivial = (i_mode.len == '0) || i_mode.lead_nul;

    // saturating byte count including the byte of this request
    always_comb begin
        n_seen = r_seen;
        if (i_step.take && r_seen != OffsetMax) begin
            n_seen = r_seen + 1'b1;
        end
    end

    assign match = i_step.take && !trivial && (n_seen >= len_ext) && i_step.all_eq;

    // first or last occurrence record
    always_comb begin
        n_hit = r_hit;
        n_off = r_off;
        if (match && (i_mode.search_last || !r_hit)) begin
            n_hit = 1'b1;
            n_off = (n_seen == OffsetMax) ? OffsetMax : n_seen - len_ext;
        end
    end

    // decision for a final request
    always_comb begin
        o_res = '0;
        if (len_ext > n_seen) begin
            o_res = '0;
        end else if (trivial) begin
            o_res.found  = 1'b1;
            o_res.offset = i_mode.search_last ? OUT_OFFSET_W'(n_seen) : '0;
        end else if (n_hit) begin
            o_res.found  = 1'b1;
            o_res.offset = OUT_OFFSET_W'(n_off);
        end
    end

    // text state, cleared after each final request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_hit  <= 1'b0;
            r_off  <= '0;
        end else if (i_step.accept && i_step.last) begin
            r_seen <= '0;
            r_hit  <= 1'b0;
            r_off  <= '0;
        end else begin
            r_seen <= n_seen;
            r_hit  <= n_hit;
            r_off  <= n_off;
        end
    end

    // no record means a zero offset
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hit |-> r_off == '0)
        else $error("offset set without a recorded occurrence");

    // a recorded offset never passes the byte count
    a_off_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_off <= r_seen)
        else $error("occurrence offset beyond bytes seen");

    // a final request leaves clean text state
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.accept && i_step.last) |=> (r_seen == '0 && !r_hit))
        else $error("text state not cleared after final request");

endmodule

[hw/rtl/substring_search_stream.sv]
// substring_search_stream: top level, config registers, window cell chain, result register
// depends on ssrch_pkg, ssrch_cell, ssrch_track
//
// channel  direction  handshake             payload
// s        in         i_s_tvalid/o_s_tready  tdata text_byte, tuser has_byte, tlast end_of_text
// m        out        o_m_tvalid/i_m_tready  tdata match_offset, tuser found
// cfg      in         i_cfg_we               i_cfg_index, i_cfg_wdata
//
// one text byte per cycle while o_s_tready is high: the window shifts and all cells compare in the accept cycle
// the result of a final request is in the output register in the cycle after it is accepted
// o_s_tready drops only while a result waits and the sink stalls
// reset (synchronous, active low) clears registers, window and text state; no clearing pass
module substring_search_stream
    import ssrch_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // text requests
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [7:0]              i_s_tdata,   // [7:0] text_byte
    input  logic                    i_s_tuser,   // [0] has_byte
    input  logic                    i_s_tlast,
    // results
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_OFFSET_W-1:0] o_m_tdata,   // [31:0] match_offset
    output logic                    o_m_tuser,   // [0] found
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_pat_len;
    logic                  r_fold;
    logic                  r_last;

    logic [7:0]            pat_byte [PAT_BYTES];
    logic [LEN_W-1:0]      used_len;
    logic                  accept_in;
    logic                  take;
    logic                  clear;
    logic [7:0]            win     [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;
    t_step                 step;
    t_mode                 mode;
    t_result               res;

    logic                    r_out_valid;
    logic                    r_found;
    logic [OUT_OFFSET_W-1:0] r_off;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
            r_fold    <= 1'b0;
            r_last    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_wdata;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_wdata;
                CFG_PAT_LEN: r_pat_len <= i_cfg_wdata[LEN_W-1:0];
                CFG_FOLD:    r_fold    <= i_cfg_wdata[0];
                CFG_LAST:    r_last    <= i_cfg_wdata[0];
                default:     ;
            endcase
        end
    end

    // pattern bytes and saturated length
    always_comb begin
        for (int j = 0; j < PAT_BYTES / 2; j++) begin
            pat_byte[j]                 = r_pat_lo[j*8 +: 8];
            pat_byte[j + PAT_BYTES / 2] = r_pat_hi[j*8 +: 8];
        end
    end

    assign used_len = (r_pat_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_pat_len;

    // input handshake
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept_in  = i_s_tvalid && o_s_tready;
    assign take       = accept_in && i_s_tuser;
    assign clear      = accept_in && i_s_tlast;

    // window chain: cell k holds the text byte k places back and checks pattern byte len-1-k
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [7:0]       din;
        logic [LEN_W-1:0] pidx;

        if (k == 0) begin : g_head
            assign din = i_s_tdata;
        end else begin : g_link
            assign din = win[k-1];
        end

        assign pidx = used_len - 1'b1 - LEN_W'(k);

        ssrch_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (take),
            .i_clear  (clear),
            .i_din    (din),
            .i_pat    (pat_byte[pidx[PAT_IDX_W-1:0]]),
            .i_active (LEN_W'(k) < used_len),
            .i_fold   (r_fold),
            .o_byte   (win[k]),
            .o_eq     (eq[k])
        );
    end

    // tracker
    assign step.accept      = accept_in;
    assign step.take        = take;
    assign step.last        = i_s_tlast;
    assign step.all_eq      = &eq;
    assign mode.len         = used_len;
    assign mode.lead_nul    = (pat_byte[0] == 8'h00);
    assign mode.search_last = r_last;

    ssrch_track #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_mode  (mode),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (clear) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_found <= res.found;
            r_off   <= res.offset;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_off;
    assign o_m_tuser  = r_found;

    // not found always carries a zero offset
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> r_off == '0)
        else $error("nonzero offset on a not-found result");

    // a final request produces a result next cycle
    a_final_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clear |=> r_out_valid)
        else $error("final request gave no result");

    // no result appears without a final request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !clear |=> !$rose(r_out_valid))
        else $error("result without a final request");

endmodule
